FILE: sv/wft_pkg.sv
// shared types and constants for the word frequency table
package wft_pkg;

  localparam int MaxEntries = 1024;
  localparam int WordChars  = 49;
  localparam int IdxW       = 10;
  localparam int UsedW      = 11;
  localparam int LenW       = 6;
  localparam int PosW       = 6;
  localparam int CountW     = 24;
  localparam int TotalW     = 32;
  localparam int CharAddrW  = 16;

  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [TotalW-1:0] TotalMax = '1;

  localparam logic [1:0] StExisting = 2'd0;
  localparam logic [1:0] StNew      = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  localparam logic KindWord   = 1'b0;
  localparam logic KindReport = 1'b1;

  typedef struct packed {
    logic            report;
    logic            has_word;
    logic [LenW-1:0] len;
    logic            trunc;
  } job_t;

  typedef struct packed {
    logic              result_kind;
    logic [IdxW-1:0]   entry_index;
    logic [CountW-1:0] entry_count;
    logic [1:0]        word_status;
    logic              word_truncated;
    logic [TotalW-1:0] total_words;
    logic [UsedW-1:0]  distinct_words;
    logic [CountW-1:0] max_count;
    logic [IdxW-1:0]   max_index;
    logic [CountW-1:0] min_count;
    logic [IdxW-1:0]   min_index;
    logic              last_result;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

endpackage

FILE: sv/wft_if.sv
// valid/ready channels for text input and results
interface wft_in_if;
  import wft_pkg::*;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] text_byte;
  modport source (output valid, mode, text_byte, input ready);
  modport sink (input valid, mode, text_byte, output ready);
endinterface

interface wft_out_if;
  import wft_pkg::*;
  logic valid;
  logic ready;
  res_t res;
  modport source (output valid, res, input ready);
  modport sink (input valid, res, output ready);
endinterface

FILE: sv/word_frequency_table.sv
// Word frequency table. Text bytes are taken one per cycle while a word is
// collected. At a word end the input stalls while the back end walks the
// table: it checks each entry's length, compares the characters of an entry
// of matching length, then raises a known word's count; a new word is copied
// into the next free entry instead. A report scans every used entry for the
// largest and smallest count; a result word held back by the sink stalls
// everything behind it. Results leave through a registered output word.
module word_frequency_table import wft_pkg::*; (
  input logic clk,
  input logic rst,
  wft_in_if.sink    in_ch,
  wft_out_if.source out_ch
);
  logic            job_valid, job_take;
  job_t            job;
  logic [PosW-1:0] rd_pos;
  logic [7:0]      rd_char;

  wft_front u_front (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_byte  (in_ch.text_byte),
    .in_ready (in_ch.ready),
    .job_valid, .job, .job_take, .rd_pos, .rd_char
  );

  wft_back u_back (
    .clk, .rst,
    .job_valid, .job, .job_take, .rd_pos, .rd_char,
    .res_valid (out_ch.valid),
    .res       (out_ch.res),
    .res_ready (out_ch.ready)
  );

  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    job_take |-> job_valid) else $error("job taken while none queued");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> !in_ch.ready) else $error("input accepted during table work");
  a_report_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.res.result_kind == KindReport) |-> out_ch.res.last_result)
    else $error("report not marked last");
endmodule

FILE: sv/wft_front.sv
// front end: splits bytes into words and queues word and report jobs
module wft_front import wft_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_mode,
  input  logic [7:0]      in_byte,
  output logic            in_ready,
  output logic            job_valid,
  output job_t            job,
  input  logic            job_take,
  input  logic [PosW-1:0] rd_pos,
  output logic [7:0]      rd_char
);
  logic [7:0]      pend [WordChars];
  logic [LenW-1:0] plen;
  logic            povf;
  logic            lpun;
  logic            busy;
  logic            fire;
  logic [7:0]      lc;
  logic [LenW-1:0] trim_len;
  logic            has;

  assign in_ready  = !busy;
  assign fire      = in_valid && in_ready;
  assign lc        = (in_byte >= 8'd65 && in_byte <= 8'd90) ? in_byte + 8'd32 : in_byte;
  assign has       = (plen != '0) || povf;
  assign trim_len  = (plen != '0 && lpun) ? plen - 1'b1 : plen;
  assign job_valid = busy;

  always_ff @(posedge clk) begin
    rd_char <= pend[rd_pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
      povf <= 1'b0;
      lpun <= 1'b0;
      busy <= 1'b0;
      job  <= '0;
    end else if (busy) begin
      if (job_take) begin
        busy <= 1'b0;
        plen <= '0;
        povf <= 1'b0;
        lpun <= 1'b0;
      end
    end else if (fire) begin
      if (in_mode || is_space(in_byte)) begin
        if (in_mode || has) begin
          busy         <= 1'b1;
          job.report   <= in_mode;
          job.has_word <= has;
          job.len      <= trim_len;
          job.trunc    <= povf;
        end
      end else if (plen < LenW'(WordChars)) begin
        pend[plen[PosW-1:0]] <= lc;
        plen                 <= plen + 1'b1;
        lpun                 <= is_punct(lc);
      end else begin
        povf <= 1'b1;
      end
    end
  end
endmodule

FILE: sv/wft_back.sv
// back end: table search, update and report scan over the entry memories
module wft_back import wft_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            job_valid,
  input  job_t            job,
  output logic            job_take,
  output logic [PosW-1:0] rd_pos,
  input  logic [7:0]      rd_char,
  output logic            res_valid,
  output res_t            res,
  input  logic            res_ready
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LEN   = 9'b000000010,
    S_CMP   = 9'b000000100,
    S_INC   = 9'b000001000,
    S_COPY  = 9'b000010000,
    S_WOUT  = 9'b000100000,
    S_SCAN  = 9'b001000000,
    S_ROUT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  logic [7:0]        chars_mem  [MaxEntries*WordChars];
  logic [LenW-1:0]   len_mem    [MaxEntries];
  logic [CountW-1:0] cnt_mem    [MaxEntries];

  state_t            state;
  logic [UsedW-1:0]  used;
  logic [TotalW-1:0] total;
  logic [IdxW-1:0]   idx;
  logic [PosW-1:0]   pos;
  logic [LenW-1:0]   len_q;
  logic [CountW-1:0] cnt_q;
  logic [7:0]        chr_q;
  logic              rd_ok;
  logic [UsedW-1:0]  scan;
  logic [CountW-1:0] mx, mn;
  logic [IdxW-1:0]   mxi, mni;
  logic [CharAddrW-1:0] caddr;
  logic              hold;
  logic              res_load;
  res_t              res_word;
  res_t              res_rep;

  assign rd_pos   = pos;
  assign caddr    = CharAddrW'(idx * WordChars + pos);
  assign job_take = (state == S_DONE);

  always_ff @(posedge clk) begin
    len_q <= len_mem[idx];
    cnt_q <= cnt_mem[idx];
    chr_q <= chars_mem[caddr];
  end

  assign hold     = res_valid && !res_ready;
  assign res_load = ((state == S_WOUT) || (state == S_ROUT)) && !hold;

  always_comb begin
    res_word                = '0;
    res_word.result_kind    = KindWord;
    res_word.word_truncated = job.trunc;
    res_word.last_result    = !job.report;
    if (state == S_INC) begin
      res_word.entry_index = idx;
      res_word.entry_count = (cnt_q != CountMax) ? cnt_q + 1'b1 : cnt_q;
      res_word.word_status = StExisting;
    end else if (used != UsedW'(MaxEntries)) begin
      res_word.entry_index = idx;
      res_word.entry_count = CountW'(1);
      res_word.word_status = StNew;
    end else begin
      res_word.word_status = StFull;
    end
    res_rep                = '0;
    res_rep.result_kind    = KindReport;
    res_rep.total_words    = total;
    res_rep.distinct_words = used;
    res_rep.max_count      = mx;
    res_rep.max_index      = mxi;
    res_rep.min_count      = mn;
    res_rep.min_index      = mni;
    res_rep.last_result    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      total     <= '0;
      rd_ok     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid && !res_valid) begin
            idx   <= '0;
            pos   <= '0;
            rd_ok <= 1'b0;
            if (job.has_word) begin
              state <= (used == '0) ? S_COPY : S_LEN;
            end else begin
              scan  <= '0;
              mx    <= '0;
              mn    <= '0;
              mxi   <= '0;
              mni   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_LEN: begin
          pos <= '0;
          if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
            if (len_q == job.len) begin
              state <= S_CMP;
            end else if (UsedW'(idx) + 1'b1 == used) begin
              idx   <= IdxW'(used);
              state <= S_COPY;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_CMP: begin
          if (LenW'(pos) == job.len) begin
            rd_ok <= 1'b0;
            state <= S_INC;
          end else if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
            if (chr_q == rd_char) begin
              pos <= pos + 1'b1;
            end else begin
              pos <= '0;
              if (UsedW'(idx) + 1'b1 == used) begin
                idx   <= IdxW'(used);
                state <= S_COPY;
              end else begin
                idx   <= idx + 1'b1;
                state <= S_LEN;
              end
            end
          end
        end
        S_INC: begin
          rd_ok <= 1'b1;
          if (rd_ok) begin
            res <= res_word;
            if (cnt_q != CountMax) begin
              cnt_mem[idx] <= cnt_q + 1'b1;
              if (total != TotalMax) total <= total + 1'b1;
            end
            state <= S_WOUT;
          end
        end
        S_COPY: begin
          if (used == UsedW'(MaxEntries)) begin
            res   <= res_word;
            state <= S_WOUT;
          end else if (LenW'(pos) == job.len) begin
            len_mem[idx] <= job.len;
            cnt_mem[idx] <= CountW'(1);
            used         <= used + 1'b1;
            if (total != TotalMax) total <= total + 1'b1;
            res          <= res_word;
            state        <= S_WOUT;
          end else if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else begin
            rd_ok            <= 1'b0;
            chars_mem[caddr] <= rd_char;
            pos              <= pos + 1'b1;
          end
        end
        S_WOUT: begin
          if (!hold) begin
            if (job.report) begin
              scan  <= '0;
              idx   <= '0;
              rd_ok <= 1'b0;
              mx    <= '0;
              mn    <= '0;
              mxi   <= '0;
              mni   <= '0;
              state <= S_SCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN: begin
          if (scan == used) begin
            state <= S_ROUT;
          end else if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else begin
            rd_ok <= 1'b0;
            if (scan == '0) begin
              mx <= cnt_q;
              mn <= cnt_q;
            end else begin
              if (cnt_q > mx) begin
                mx  <= cnt_q;
                mxi <= idx;
              end
              if (cnt_q < mn) begin
                mn  <= cnt_q;
                mni <= idx;
              end
            end
            scan <= scan + 1'b1;
            idx  <= idx + 1'b1;
          end
        end
        S_ROUT: begin
          if (!hold) begin
            res   <= res_rep;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: tb/word_frequency_table_test.sv
// testbench for the word frequency table: random text against a scoreboard
module word_frequency_table_test;
  import wft_pkg::*;

  class freq_scoreboard;
    byte unsigned entry_text[$][$];
    int unsigned entry_cnt[$];
    byte unsigned pend[$];
    bit pend_over;
    bit [TotalW-1:0] total;
    res_t expected_q[$];
    int errors;

    function void close_word();
      res_t r;
      int found;
      r = '0;
      r.result_kind = KindWord;
      r.word_truncated = pend_over;
      if (pend.size() > 0 && is_punct(pend[pend.size()-1])) void'(pend.pop_back());
      found = -1;
      foreach (entry_text[i]) if (found < 0 && entry_text[i] == pend) found = i;
      if (found >= 0) begin
        if (entry_cnt[found] < CountMax) begin
          entry_cnt[found]++;
          if (total != TotalMax) total++;
        end
        r.entry_index = found[IdxW-1:0];
        r.entry_count = CountW'(entry_cnt[found]);
        r.word_status = StExisting;
      end else if (entry_cnt.size() < MaxEntries) begin
        r.entry_index = IdxW'(entry_cnt.size());
        entry_text.push_back(pend);
        entry_cnt.push_back(1);
        if (total != TotalMax) total++;
        r.entry_count = CountW'(1);
        r.word_status = StNew;
      end else begin
        r.word_status = StFull;
      end
      expected_q.push_back(r);
      pend = {};
      pend_over = 0;
    endfunction

    function void note_input(logic mode, logic [7:0] c);
      res_t r;
      int mx, mn, mxi, mni;
      if (mode) begin
        if (pend.size() > 0 || pend_over) close_word();
        r = '0;
        r.result_kind = KindReport;
        r.total_words = total;
        r.distinct_words = UsedW'(entry_cnt.size());
        mx = 0; mn = 0; mxi = 0; mni = 0;
        if (entry_cnt.size() > 0) begin
          mx = entry_cnt[0];
          mn = entry_cnt[0];
        end
        foreach (entry_cnt[i]) begin
          if (entry_cnt[i] > mx) begin mx = entry_cnt[i]; mxi = i; end
          if (entry_cnt[i] < mn) begin mn = entry_cnt[i]; mni = i; end
        end
        r.max_count = CountW'(mx);
        r.max_index = IdxW'(mxi);
        r.min_count = CountW'(mn);
        r.min_index = IdxW'(mni);
        expected_q.push_back(r);
        expected_q[expected_q.size()-1].last_result = 1;
      end else if (is_space(c)) begin
        if (pend.size() > 0 || pend_over) begin
          close_word();
          expected_q[expected_q.size()-1].last_result = 1;
        end
      end else begin
        if (c >= 8'd65 && c <= 8'd90) c = c + 8'd32;
        if (pend.size() < WordChars) pend.push_back(c);
        else pend_over = 1;
      end
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result %p", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got !== e) begin
        $display("%0t mismatch expected %p actual %p", $time, e, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  wft_in_if in_ch();
  wft_out_if out_ch();
  word_frequency_table u_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  freq_scoreboard sb = new();
  int idle_cycles;
  int out_wait;
  int draw;
  string vocab[8] = '{"the", "Cat,", "cat", "a.", "dog", "THE", "x", "!"};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic send_word(logic mode, logic [7:0] c);
    int gap;
    gap = $urandom_range(0, 4);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.text_byte <= c;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(mode, c);
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_word(1'b0, s[i]);
    send_word(1'b0, 8'd32);
  endtask

  task automatic send_random_bytes(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 9);
      if (k < 5) send_text(vocab[$urandom_range(0, 7)]);
      else if (k < 6) send_word(1'b0, 8'($urandom_range(0, 255)));
      else if (k < 7) send_word(1'b0, 8'($urandom_range(9, 13)));
      else if (k < 8) begin
        for (int j = $urandom_range(1, 6); j > 0; j--)
          send_word(1'b0, 8'($urandom_range(33, 126)));
        send_word(1'b0, 8'd32);
      end else if (k < 9) send_word(1'b1, 8'($urandom_range(0, 255)));
      else send_word(1'b0, 8'($urandom_range(65, 90)));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_wait <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.res);
      draw = $urandom_range(0, 4);
      out_wait <= draw;
      out_ch.ready <= (draw == 0);
    end else if (!out_ch.ready) begin
      if (out_wait == 0) begin
        out_ch.ready <= 1'b1;
      end else if (out_ch.valid) begin
        out_wait <= out_wait - 1;
        if (out_wait == 1) out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 400000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    string longw;
    rst = 1;
    in_ch.valid = 0;
    in_ch.mode = 0;
    in_ch.text_byte = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    send_word(1'b1, 8'hff);
    send_word(1'b0, 8'd32);
    send_text("Hello, hello HELLO!");
    send_word(1'b0, 8'd9);
    send_word(1'b0, 8'd13);
    send_text("?");
    send_word(1'b0, 8'd0);
    send_word(1'b0, 8'd255);
    send_word(1'b0, 8'd128);
    send_word(1'b0, 8'd10);
    longw = "";
    for (int i = 0; i < 55; i++) longw = {longw, "q"};
    longw = {longw, "."};
    send_text(longw);
    send_word(1'b0, "z");
    send_word(1'b1, 8'h00);
    send_random_bytes(500);
    send_word(1'b1, 8'h00);
    in_ch.valid <= 1'b0;
    wait (sb.expected_q.size() == 0);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

FILE: sim.f
sv/wft_pkg.sv
sv/wft_if.sv
sv/wft_front.sv
sv/wft_back.sv
sv/word_frequency_table.sv
tb/word_frequency_table_test.sv
